@@ rtl/gp_kernel_covariance_eval_assert.svh @@
// Assertion macros for the top-level RTL file.
`ifndef GP_KERNEL_COVARIANCE_EVAL_ASSERT_SVH
`define GP_KERNEL_COVARIANCE_EVAL_ASSERT_SVH
`ifndef ASSERT_OFF
`define GKC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gkc assertion failed");
`define GKC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gkc assertion failed");
`else
`define GKC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GKC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/gkc_pkg.sv @@
package gkc_pkg;

    typedef struct packed {
        logic signed [31:0] coord_a;
        logic signed [31:0] coord_b;
        logic [31:0]        inv_length;
        logic               last_dim;
    } t_in;

    typedef struct packed {
        logic [31:0] covariance;
        logic        sum_saturated;
    } t_out;

    localparam logic [2:0] MODE_GAUSS = 3'd0;
    localparam logic [2:0] MODE_EXP   = 3'd1;
    localparam logic [2:0] MODE_M32   = 3'd2;
    localparam logic [2:0] MODE_M52   = 3'd3;
    localparam logic [2:0] MODE_WN    = 3'd4;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_VAR  = 1'b1;

    localparam logic [31:0] LN2_Q30 = 32'd744261118;
    localparam logic [30:0] ONE_30  = 31'h4000_0000;
    localparam logic [33:0] SC_G_Q32 = 34'd3037000500;
    localparam logic [33:0] SC_3_Q32 = 34'd7439101574;
    localparam logic [33:0] SC_5_Q32 = 34'd9603838835;

    // Reciprocals for the divisions by constants; the quotient is the high part of the product.
    localparam logic [63:0] RECIP_3   = 64'hAAAA_AAAA_AAAA_AAAB;
    localparam logic [63:0] RECIP_LN2 = 64'((65'd1 << 64) / 65'(LN2_Q30));

    localparam logic [4:0] OP_NONE     = 5'd0;
    localparam logic [4:0] OP_LOAD     = 5'd1;
    localparam logic [4:0] OP_SET_P    = 5'd2;
    localparam logic [4:0] OP_SET_E    = 5'd3;
    localparam logic [4:0] OP_TERM_AD  = 5'd4;
    localparam logic [4:0] OP_TERM_E   = 5'd5;
    localparam logic [4:0] OP_TERM_SQ  = 5'd6;
    localparam logic [4:0] OP_TERM_LN  = 5'd7;
    localparam logic [4:0] OP_LNARG2   = 5'd8;
    localparam logic [4:0] OP_Q        = 5'd9;
    localparam logic [4:0] OP_LNARG3   = 5'd10;
    localparam logic [4:0] OP_LN_INIT  = 5'd11;
    localparam logic [4:0] OP_NORM     = 5'd12;
    localparam logic [4:0] OP_LN_M     = 5'd13;
    localparam logic [4:0] OP_SQ_STEP  = 5'd14;
    localparam logic [4:0] OP_V1       = 5'd15;
    localparam logic [4:0] OP_V2       = 5'd16;
    localparam logic [4:0] OP_ACC      = 5'd17;
    localparam logic [4:0] OP_EXP_INIT = 5'd18;
    localparam logic [4:0] OP_EXP_NR   = 5'd19;
    localparam logic [4:0] OP_H1       = 5'd20;
    localparam logic [4:0] OP_H2       = 5'd21;
    localparam logic [4:0] OP_COV_EXP  = 5'd22;
    localparam logic [4:0] OP_COV_ZERO = 5'd23;
    localparam logic [4:0] OP_COV_WN   = 5'd24;
    localparam logic [4:0] OP_EMIT     = 5'd25;

    localparam logic [3:0] MS_AD_INV  = 4'd0;
    localparam logic [3:0] MS_P_SCALE = 4'd1;
    localparam logic [3:0] MS_EE      = 4'd2;
    localparam logic [3:0] MS_MM      = 4'd3;
    localparam logic [3:0] MS_KLN     = 4'd4;
    localparam logic [3:0] MS_FLN     = 4'd5;
    localparam logic [3:0] MS_RP      = 4'd6;
    localparam logic [3:0] MS_VP      = 4'd7;
    localparam logic [3:0] MS_R3      = 4'd8;
    localparam logic [3:0] MS_RLN     = 4'd9;

    typedef struct packed {
        logic [4:0] op;
        logic       mgo;
        logic [3:0] msel;
        logic       dgo;
    } t_cmd;

    typedef struct packed {
        logic       mul_busy;
        logic       div_busy;
        logic [2:0] mode;
        logic       last;
        logic       ln_small;
        logic       norm_top;
        logic       sq_last;
        logic       big;
        logic       n_big;
        logic       kk_one;
        logic       out_free;
    } t_sts;

    function automatic logic [63:0] f_to_frac(input logic [33:0] c32, input int frac);
        logic [63:0] c;
        c = 64'(c32);
        return (c + (64'd1 << (31 - frac))) >> (32 - frac);
    endfunction

endpackage

@@ rtl/gkc_mul.sv @@
module gkc_mul
    import gkc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_busy,
    output logic [127:0] o_prod
);

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [127:0] r_acc;
    logic [1:0]   r_cnt;
    logic         r_busy;
    logic [31:0]  w_ah;
    logic [31:0]  w_bh;
    logic [1:0]   w_hsum;
    logic [127:0] w_pp;

    always_comb begin
        w_ah   = r_cnt[1] ? r_a[63:32] : r_a[31:0];
        w_bh   = r_cnt[0] ? r_b[63:32] : r_b[31:0];
        w_hsum = {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
        w_pp   = 128'(w_ah * w_bh) << {w_hsum, 5'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 2'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 2'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 2'd1;
            if (r_cnt == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_pp;
        end
    end

    assign o_busy = r_busy;
    assign o_prod = r_acc;

endmodule

@@ rtl/gkc_div.sv @@
module gkc_div
    import gkc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic [63:0] o_quot
);

    logic [63:0] r_dd;
    logic [31:0] r_rem;
    logic [31:0] r_dv;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] w_sh;
    logic [32:0] w_tr;

    always_comb begin
        w_sh = {r_rem, r_dd[63]};
        w_tr = w_sh - {1'b0, r_dv};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 6'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dd  <= i_dividend;
            r_rem <= '0;
            r_dv  <= i_divisor;
        end else if (r_busy) begin
            if (!w_tr[32]) begin
                r_rem <= w_tr[31:0];
                r_dd  <= {r_dd[62:0], 1'b1};
            end else begin
                r_rem <= w_sh[31:0];
                r_dd  <= {r_dd[62:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_dd;

endmodule

@@ rtl/gkc_dp.sv @@
module gkc_dp
    import gkc_pkg::*;
#(
    parameter int ACC_WIDTH = 48,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  t_in         i_in_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output t_out        o_out_data
);

    localparam logic [63:0] ACC_MAX = 64'((65'd1 << ACC_WIDTH) - 65'd1);
    localparam logic [63:0] ONE_F   = 64'd1 << FRAC_BITS;
    localparam logic [63:0] SC_G    = f_to_frac(SC_G_Q32, FRAC_BITS);
    localparam logic [63:0] SC_3    = f_to_frac(SC_3_Q32, FRAC_BITS);
    localparam logic [63:0] SC_5    = f_to_frac(SC_5_Q32, FRAC_BITS);
    localparam logic [63:0] BIG_SUM = 64'd64 << FRAC_BITS;
    localparam logic [63:0] LN_RND  = 64'd1 << (29 - FRAC_BITS);

    logic [2:0]           r_mode;
    logic [31:0]          r_var;
    logic [ACC_WIDTH-1:0] r_sum;
    logic                 r_sat;
    logic                 r_ovalid;
    t_out                 r_out;
    logic [2:0]           r_imode;
    logic                 r_last;
    logic [32:0]          r_ad;
    logic [31:0]          r_inv;
    logic [63:0]          r_t;
    logic [63:0]          r_e;
    logic [63:0]          r_term;
    logic [63:0]          r_lnarg;
    logic                 r_qovf;
    logic [63:0]          r_norm;
    logic [5:0]           r_k;
    logic [30:0]          r_m;
    logic [29:0]          r_frac;
    logic [4:0]           r_cnt;
    logic [63:0]          r_v;
    logic [63:0]          r_ln;
    logic [6:0]           r_n;
    logic [29:0]          r_r;
    logic [30:0]          r_p;
    logic [3:0]           r_kk;
    logic [31:0]          r_cov;

    logic                 w_mbusy;
    logic [127:0]         w_prod;
    logic                 w_dbusy;
    logic [63:0]          w_quot;
    logic [63:0]          w_ma;
    logic [63:0]          w_mb;
    logic [31:0]          w_dv;
    logic [63:0]          w_scale;
    logic signed [32:0]   w_d;
    logic                 w_hi;
    logic [63:0]          w_lo_f;
    logic [63:0]          w_sum64;
    logic                 w_tsat;
    logic [63:0]          w_tclip;
    logic [64:0]          w_acc;
    logic                 w_asat;
    logic [64:0]          w_a1;
    logic [63:0]          w_s1;
    logic [64:0]          w_a2;
    logic [63:0]          w_q;
    logic [31:0]          w_sq;
    logic [63:0]          w_vs;
    logic [6:0]           w_sh;
    logic [64:0]          w_rnd;
    logic [6:0]           w_ne;
    logic [36:0]          w_nl;
    logic [36:0]          w_rr;
    logic                 w_fix;
    logic [36:0]          w_rr2;

    gkc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mgo),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_busy  (w_mbusy),
        .o_prod  (w_prod)
    );

    gkc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.dgo),
        .i_dividend (r_t),
        .i_divisor  (w_dv),
        .o_busy     (w_dbusy),
        .o_quot     (w_quot)
    );

    always_comb begin
        case (r_imode)
            MODE_GAUSS: w_scale = SC_G;
            MODE_M32:   w_scale = SC_3;
            MODE_M52:   w_scale = SC_5;
            default:    w_scale = ONE_F;
        endcase
        case (i_cmd.msel)
            MS_AD_INV:  begin w_ma = 64'(r_ad);   w_mb = 64'(r_inv);   end
            MS_P_SCALE: begin w_ma = r_t;         w_mb = w_scale;      end
            MS_EE:      begin w_ma = r_e;         w_mb = r_e;          end
            MS_MM:      begin w_ma = 64'(r_m);    w_mb = 64'(r_m);     end
            MS_KLN:     begin w_ma = 64'(r_k) - 64'(FRAC_BITS); w_mb = 64'(LN2_Q30); end
            MS_FLN:     begin w_ma = 64'(r_frac); w_mb = 64'(LN2_Q30); end
            MS_RP:      begin w_ma = 64'(r_r);    w_mb = 64'(r_p);     end
            MS_VP:      begin w_ma = 64'(r_var);  w_mb = 64'(r_p);     end
            MS_R3:      begin w_ma = r_t;         w_mb = RECIP_3;      end
            MS_RLN:     begin w_ma = r_t;         w_mb = RECIP_LN2;    end
            default:    begin w_ma = '0;          w_mb = '0;           end
        endcase
        w_dv = 32'(r_kk);
    end

    always_comb begin
        w_d     = {i_in_data.coord_a[31], i_in_data.coord_a}
                - {i_in_data.coord_b[31], i_in_data.coord_b};
        w_hi    = |w_prod[127:64];
        w_lo_f  = w_prod[63:0] >> FRAC_BITS;
        w_sum64 = 64'(r_sum);
        w_tsat  = r_term > ACC_MAX;
        w_tclip = w_tsat ? ACC_MAX : r_term;
        w_acc   = {1'b0, w_sum64} + {1'b0, w_tclip};
        w_asat  = w_acc > {1'b0, ACC_MAX};
        w_a1    = {1'b0, ONE_F} + {1'b0, r_e};
        w_s1    = w_a1[64] ? '1 : w_a1[63:0];
        w_q     = r_qovf ? '1 : {1'b0, w_prod[127:65]};
        w_a2    = {1'b0, w_s1} + {1'b0, w_q};
        w_sq    = w_prod[61:30];
        w_vs    = r_v + 64'(w_prod >> 30) + LN_RND;
        w_sh    = 7'd30 + r_n;
        w_rnd   = ({1'b0, w_prod[63:0]} + (65'd1 << (w_sh - 7'd1))) >> w_sh;
        w_ne    = w_prod[70:64];
        w_nl    = 37'(w_ne) * 37'(LN2_Q30);
        w_rr    = r_t[36:0] - w_nl;
        w_fix   = w_rr >= 37'(LN2_Q30);
        w_rr2   = w_fix ? w_rr - 37'(LN2_Q30) : w_rr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_GAUSS;
            r_var    <= 32'd65536;
            r_sum    <= '0;
            r_sat    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MODE: r_mode <= i_cfg_data[2:0];
                    CFG_VAR:  r_var  <= i_cfg_data;
                    default:  r_var  <= r_var;
                endcase
            end
            if (i_cmd.op == OP_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd.op)
                OP_SET_E: begin
                    if (w_hi || w_lo_f > ACC_MAX) begin
                        r_sat <= 1'b1;
                    end
                end
                OP_ACC: begin
                    r_sum <= w_asat ? ACC_WIDTH'(ACC_MAX) : ACC_WIDTH'(w_acc);
                    if (w_tsat || w_asat) begin
                        r_sat <= 1'b1;
                    end
                end
                OP_EMIT: begin
                    r_sum <= '0;
                    r_sat <= 1'b0;
                end
                default: r_sat <= r_sat;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_ad    <= w_d[32] ? 33'(~w_d + 33'sd1) : 33'(w_d);
                r_inv   <= i_in_data.inv_length;
                r_last  <= i_in_data.last_dim;
                r_imode <= r_mode;
            end
            OP_SET_P:   r_t <= 64'(w_prod >> FRAC_BITS);
            OP_SET_E:   r_e <= (w_hi || w_lo_f > ACC_MAX) ? ACC_MAX : w_lo_f;
            OP_TERM_AD: r_term <= 64'(r_ad);
            OP_TERM_E:  r_term <= r_e;
            OP_TERM_SQ: r_term <= w_hi ? '1 : w_lo_f;
            OP_TERM_LN: r_term <= (r_ln > r_e) ? '0 : r_e - r_ln;
            OP_LNARG2:  r_lnarg <= w_s1;
            OP_Q: begin
                r_t    <= w_hi ? '1 : w_lo_f;
                r_qovf <= w_hi;
            end
            OP_LNARG3:  r_lnarg <= w_a2[64] ? '1 : w_a2[63:0];
            OP_LN_INIT: begin
                r_norm <= r_lnarg;
                r_k    <= 6'd63;
                r_ln   <= '0;
            end
            OP_NORM: begin
                r_norm <= {r_norm[62:0], 1'b0};
                r_k    <= r_k - 6'd1;
            end
            OP_LN_M: begin
                r_m    <= r_norm[63:33];
                r_frac <= '0;
                r_cnt  <= '0;
            end
            OP_SQ_STEP: begin
                if (w_sq[31]) begin
                    r_m                  <= w_sq[31:1];
                    r_frac[5'd29 - r_cnt] <= 1'b1;
                end else begin
                    r_m <= w_sq[30:0];
                end
                r_cnt <= r_cnt + 5'd1;
            end
            OP_V1:       r_v <= w_prod[63:0];
            OP_V2:       r_ln <= w_vs >> (30 - FRAC_BITS);
            OP_EXP_INIT: r_t <= w_sum64 << (30 - FRAC_BITS);
            OP_EXP_NR: begin
                r_n  <= w_ne + {6'd0, w_fix};
                r_r  <= w_rr2[29:0];
                r_p  <= ONE_30;
                r_kk <= 4'd14;
            end
            OP_H1: r_t <= 64'(w_prod >> 30);
            OP_H2: begin
                r_p  <= ONE_30 - w_quot[30:0];
                r_kk <= r_kk - 4'd1;
            end
            OP_COV_EXP:  r_cov <= w_rnd[31:0];
            OP_COV_ZERO: r_cov <= '0;
            OP_COV_WN:   r_cov <= (r_sum == '0) ? r_var : '0;
            OP_EMIT: begin
                r_out.covariance    <= r_cov;
                r_out.sum_saturated <= r_sat;
            end
            default: r_cov <= r_cov;
        endcase
    end

    always_comb begin
        o_sts.mul_busy = w_mbusy;
        o_sts.div_busy = w_dbusy;
        o_sts.mode     = r_imode;
        o_sts.last     = r_last;
        o_sts.ln_small = r_lnarg <= ONE_F;
        o_sts.norm_top = r_norm[63];
        o_sts.sq_last  = r_cnt == 5'd29;
        o_sts.big      = w_sum64 >= BIG_SUM;
        o_sts.n_big    = r_n > 7'd32;
        o_sts.kk_one   = r_kk == 4'd1;
        o_sts.out_free = !r_ovalid || !i_out_stall;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/gkc_ctrl.sv @@
module gkc_ctrl
    import gkc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall
);

    localparam logic [5:0] S_IDLE = 6'd0;
    localparam logic [5:0] S_MP   = 6'd1;
    localparam logic [5:0] S_WAIT = 6'd2;
    localparam logic [5:0] S_SETP = 6'd3;
    localparam logic [5:0] S_MSC  = 6'd4;
    localparam logic [5:0] S_SETE = 6'd5;
    localparam logic [5:0] S_TAD  = 6'd6;
    localparam logic [5:0] S_TE   = 6'd7;
    localparam logic [5:0] S_MEE  = 6'd8;
    localparam logic [5:0] S_TSQ  = 6'd9;
    localparam logic [5:0] S_Q    = 6'd10;
    localparam logic [5:0] S_DQ   = 6'd11;
    localparam logic [5:0] S_LA2  = 6'd12;
    localparam logic [5:0] S_LA3  = 6'd13;
    localparam logic [5:0] S_LNI  = 6'd14;
    localparam logic [5:0] S_NORM = 6'd15;
    localparam logic [5:0] S_LNM  = 6'd16;
    localparam logic [5:0] S_SQ   = 6'd17;
    localparam logic [5:0] S_SQS  = 6'd18;
    localparam logic [5:0] S_MK   = 6'd19;
    localparam logic [5:0] S_V1   = 6'd20;
    localparam logic [5:0] S_MF   = 6'd21;
    localparam logic [5:0] S_V2   = 6'd22;
    localparam logic [5:0] S_TLN  = 6'd23;
    localparam logic [5:0] S_ACC  = 6'd24;
    localparam logic [5:0] S_CWN  = 6'd25;
    localparam logic [5:0] S_EI   = 6'd26;
    localparam logic [5:0] S_CZ   = 6'd27;
    localparam logic [5:0] S_DN   = 6'd28;
    localparam logic [5:0] S_NR   = 6'd29;
    localparam logic [5:0] S_NC   = 6'd30;
    localparam logic [5:0] S_HM   = 6'd31;
    localparam logic [5:0] S_H1   = 6'd32;
    localparam logic [5:0] S_HD   = 6'd33;
    localparam logic [5:0] S_H2   = 6'd34;
    localparam logic [5:0] S_MV   = 6'd35;
    localparam logic [5:0] S_CE   = 6'd36;
    localparam logic [5:0] S_EMIT = 6'd37;

    logic [5:0] r_state;
    logic [5:0] n_state;
    logic [5:0] r_ret;
    logic [5:0] n_ret;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_MP;
                end
            end
            S_MP: begin
                o_cmd.mgo  = 1'b1;
                o_cmd.msel = MS_AD_INV;
                n_ret      = S_SETP;
                n_state    = S_WAIT;
            end
            S_WAIT: begin
                if (!i_sts.mul_busy && !i_sts.div_busy) begin
                    n_state = r_ret;
                end
            end
            S_SETP: begin
                o_cmd.op = OP_SET_P;
                n_state  = S_MSC;
            end
            S_MSC: begin
                o_cmd.mgo  = 1'b1;
                o_cmd.msel = MS_P_SCALE;
                n_ret      = S_SETE;
                n_state    = S_WAIT;
            end
            S_SETE: begin
                o_cmd.op = OP_SET_E;
                case (i_sts.mode)
                    MODE_WN:    n_state = S_TAD;
                    MODE_GAUSS: n_state = S_MEE;
                    MODE_M52:   n_state = S_MEE;
                    MODE_M32:   n_state = S_LA2;
                    default:    n_state = S_TE;
                endcase
            end
            S_TAD: begin
                o_cmd.op = OP_TERM_AD;
                n_state  = S_ACC;
            end
            S_TE: begin
                o_cmd.op = OP_TERM_E;
                n_state  = S_ACC;
            end
            S_MEE: begin
                o_cmd.mgo  = 1'b1;
                o_cmd.msel = MS_EE;
                n_ret      = (i_sts.mode == MODE_GAUSS) ? S_TSQ : S_Q;
                n_state    = S_WAIT;
            end
            S_TSQ: begin
                o_cmd.op = OP_TERM_SQ;
                n_state  = S_ACC;
            end
            S_Q: begin
                o_cmd.op = OP_Q;
                n_state  = S_DQ;
            end
            S_DQ: begin
                o_cmd.mgo  = 1'b1;
                o_cmd.msel = MS_R3;
                n_ret      = S_LA3;
                n_state    = S_WAIT;
            end
            S_LA2: begin
                o_cmd.op = OP_LNARG2;
                n_state  = S_LNI;
            end
            S_LA3: begin
                o_cmd.op = OP_LNARG3;
                n_state  = S_LNI;
            end
            S_LNI: begin
                o_cmd.op = OP_LN_INIT;
                n_state  = i_sts.ln_small ? S_TLN : S_NORM;
            end
            S_NORM: begin
                if (i_sts.norm_top) begin
                    n_state = S_LNM;
                end else begin
                    o_cmd.op = OP_NORM;
                end
            end
            S_LNM: begin
                o_cmd.op = OP_LN_M;
                n_state  = S_SQ;
            end
            S_SQ: begin
                o_cmd.mgo  = 1'b1;
                o_cmd.msel = MS_MM;
                n_ret      = S_SQS;
                n_state    = S_WAIT;
            end
            S_SQS: begin
                o_cmd.op = OP_SQ_STEP;
                n_state  = i_sts.sq_last ? S_MK : S_SQ;
            end
            S_MK: begin
                o_cmd.mgo  = 1'b1;
                o_cmd.msel = MS_KLN;
                n_ret      = S_V1;
                n_state    = S_WAIT;
            end
            S_V1: begin
                o_cmd.op = OP_V1;
                n_state  = S_MF;
            end
            S_MF: begin
                o_cmd.mgo  = 1'b1;
                o_cmd.msel = MS_FLN;
                n_ret      = S_V2;
                n_state    = S_WAIT;
            end
            S_V2: begin
                o_cmd.op = OP_V2;
                n_state  = S_TLN;
            end
            S_TLN: begin
                o_cmd.op = OP_TERM_LN;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.op = OP_ACC;
                if (!i_sts.last) begin
                    n_state = S_IDLE;
                end else if (i_sts.mode == MODE_WN) begin
                    n_state = S_CWN;
                end else begin
                    n_state = S_EI;
                end
            end
            S_CWN: begin
                o_cmd.op = OP_COV_WN;
                n_state  = S_EMIT;
            end
            S_EI: begin
                o_cmd.op = OP_EXP_INIT;
                n_state  = i_sts.big ? S_CZ : S_DN;
            end
            S_CZ: begin
                o_cmd.op = OP_COV_ZERO;
                n_state  = S_EMIT;
            end
            S_DN: begin
                o_cmd.mgo  = 1'b1;
                o_cmd.msel = MS_RLN;
                n_ret      = S_NR;
                n_state    = S_WAIT;
            end
            S_NR: begin
                o_cmd.op = OP_EXP_NR;
                n_state  = S_NC;
            end
            S_NC: begin
                n_state = i_sts.n_big ? S_CZ : S_HM;
            end
            S_HM: begin
                o_cmd.mgo  = 1'b1;
                o_cmd.msel = MS_RP;
                n_ret      = S_H1;
                n_state    = S_WAIT;
            end
            S_H1: begin
                o_cmd.op = OP_H1;
                n_state  = S_HD;
            end
            S_HD: begin
                o_cmd.dgo  = 1'b1;
                n_ret      = S_H2;
                n_state    = S_WAIT;
            end
            S_H2: begin
                o_cmd.op = OP_H2;
                n_state  = i_sts.kk_one ? S_MV : S_HM;
            end
            S_MV: begin
                o_cmd.mgo  = 1'b1;
                o_cmd.msel = MS_VP;
                n_ret      = S_CE;
                n_state    = S_WAIT;
            end
            S_CE: begin
                o_cmd.op = OP_COV_EXP;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule

@@ rtl/gp_kernel_covariance_eval.sv @@
// Covariance kernel evaluator. Each input beat carries one dimension of a point pair: both
// coordinates, the inverse length scale and a last-dimension mark. The block accumulates the
// per-dimension distance term of the selected kernel and, on the last dimension, sends one
// output beat with the covariance and a flag that tells whether the accumulator saturated.
// The input channel takes one beat at a time; o_in_stall is high while a beat is in work.
// Work runs on one shared 64x64 multiplier (four 32x32 partial products) and one radix-2
// divider for the series steps, stepped by a controller.
// Divisions by constants use reciprocal multiplication on the shared multiplier.
// Per dimension, exponential and white noise take the shortest path, then gauss, then Matern 3/2
// (thirty squarings for the logarithm) and Matern 5/2, the longest.
// Outside white-noise mode the last dimension adds the exponential (range reduction, then fourteen
// multiply-divide steps of the series); it gives zero when the sum is too large for a nonzero
// result or when the range reduction leaves no nonzero result.
// Results wait in an output register; a stalled receiver holds the beat and, once the next
// result is ready, the controller waits for it. Input beats are taken while a result waits.
// The configuration port is always ready and should be written only while the block is idle.
// Reset clears the sum, the flag and the output valid, and sets gauss mode and a variance of 1.0.
`include "gp_kernel_covariance_eval_assert.svh"

module gp_kernel_covariance_eval
    import gkc_pkg::*;
#(
    parameter int ACC_WIDTH = 48,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    gkc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    gkc_dp #(
        .ACC_WIDTH (ACC_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_cfg_ready = 1'b1;

    `GKC_ASSERT_NXT(a_one_item_in_work, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `GKC_ASSERT_IMP(a_units_exclusive, i_clk, i_rst_n, w_sts.mul_busy, !w_sts.div_busy)
    `GKC_ASSERT_IMP(a_start_free, i_clk, i_rst_n, w_cmd.mgo || w_cmd.dgo, !w_sts.mul_busy)
    `GKC_ASSERT_NXT(a_emit_sets_valid, i_clk, i_rst_n, w_cmd.op == OP_EMIT, o_out_valid)

endmodule
